@@ design/quadratic_contour_to_segments_unit_assert.svh @@
// Assertion macros for the design files; the top-level unit includes them.
// QCS_ASSERT_IMP: same-cycle implication. QCS_ASSERT_NXT: next-cycle implication.
`ifndef QUADRATIC_CONTOUR_TO_SEGMENTS_UNIT_ASSERT_SVH
`define QUADRATIC_CONTOUR_TO_SEGMENTS_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define QCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QCS_ASSERT_IMP(lbl, ante, cons)
`define QCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/qcs_pkg.sv @@
package qcs_pkg;

    localparam int QCS_MAX_POINTS = 63;
    localparam int QCS_COORD_W    = 16;
    localparam int QCS_TOTAL_W    = 7;

    typedef logic signed [QCS_COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   on;
        t_coord y;
        t_coord x;
    } t_point;

    localparam int QCS_POINT_W = $bits(t_point);

endpackage

@@ design/qcs_point_if.sv @@
interface qcs_point_if import qcs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   on_curve;
    logic   closes_contour;

    modport source (output valid, point_x, point_y, on_curve, closes_contour, input ready);
    modport sink   (input valid, point_x, point_y, on_curve, closes_contour, output ready);
endinterface

@@ design/qcs_seg_if.sv @@
interface qcs_seg_if import qcs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_coord                 start_x;
    t_coord                 start_y;
    t_coord                 ctrl_x;
    t_coord                 ctrl_y;
    logic                   final_segment;
    logic [QCS_TOTAL_W-1:0] segment_total;
    logic                   points_dropped;

    modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, final_segment,
                    segment_total, points_dropped, input ready);
    modport sink   (input valid, start_x, start_y, ctrl_x, ctrl_y, final_segment,
                    segment_total, points_dropped, output ready);
endinterface

@@ design/qcs_ram.sv @@
module qcs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/qcs_mid.sv @@
// Implied on-curve midpoint: (a + b) / 2 per axis, truncated toward zero.
module qcs_mid import qcs_pkg::*; (
    input  t_point i_a,
    input  t_point i_b,
    output t_coord o_x,
    output t_coord o_y
);

    function automatic t_coord half_sum(input t_coord a, input t_coord b);
        logic signed [QCS_COORD_W:0] s;
        logic signed [QCS_COORD_W:0] adj;
        begin
            s   = {a[QCS_COORD_W-1], a} + {b[QCS_COORD_W-1], b};
            // negative odd sums round up toward zero before the shift
            adj = s + {{QCS_COORD_W{1'b0}}, s[QCS_COORD_W] & s[0]};
            half_sum = adj[QCS_COORD_W:1];
        end
    endfunction

    assign o_x = half_sum(i_a.x, i_b.x);
    assign o_y = half_sum(i_a.y, i_b.y);

endmodule

@@ design/quadratic_contour_to_segments_unit.sv @@
// A non-closing point is taken while the unit is idle; points can come back to back.
// A closing point of an n-point contour starts a build pass: wrap check, store read plus
// midpoint step per point after the first, tail, then flush of the pending slot.
// Input is ready again once the last segment sits in the output register. Output stalls
// stretch the pass. Reset (synchronous, active low) clears state, point counter, overflow
// flag and handshakes; point store contents stay.
module quadratic_contour_to_segments_unit import qcs_pkg::*; #(
    parameter int MAX_CONTOUR_POINTS = QCS_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qcs_point_if.sink   i_pt,
    qcs_seg_if.source   o_seg
);

    `include "quadratic_contour_to_segments_unit_assert.svh"

    localparam int AW = (MAX_CONTOUR_POINTS > 1) ? $clog2(MAX_CONTOUR_POINTS) : 1;
    localparam int CW = $clog2(MAX_CONTOUR_POINTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRAP  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ovf, n_ovf;
    logic [CW-1:0]          r_num, n_num;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_ovf_b, n_ovf_b;
    t_point                 r_first, n_first;
    t_point                 r_last, n_last;
    t_point                 r_prev, n_prev;
    t_coord                 r_tx, n_tx;
    t_coord                 r_ty, n_ty;
    logic                   r_pend_vld, n_pend_vld;
    t_coord                 r_pend_sx, r_pend_sy, r_pend_cx, r_pend_cy;
    logic [QCS_TOTAL_W-1:0] r_seg_cnt, n_seg_cnt;
    logic                   r_o_vld, n_o_vld;
    t_coord                 r_o_sx, r_o_sy, r_o_cx, r_o_cy;
    logic                   r_o_final;
    logic [QCS_TOTAL_W-1:0] r_o_total;
    logic                   r_o_drop;

    t_point                 in_pt;
    t_point                 rd_pt;
    logic [QCS_POINT_W-1:0] rd_data;
    logic                   accept;
    logic                   store;
    logic                   out_free;
    logic                   can_emit;
    logic                   emit_req;
    logic                   do_emit;
    logic                   flush_load;
    logic                   out_load;
    logic                   ram_re;
    logic [CW-1:0]          idx_inc;
    t_coord                 e_sx, e_sy, e_cx, e_cy;
    t_point                 mid_a, mid_b;
    t_coord                 mid_x, mid_y;

    assign in_pt    = '{on: i_pt.on_curve, y: i_pt.point_y, x: i_pt.point_x};
    assign rd_pt    = t_point'(rd_data);
    assign accept   = i_pt.valid && i_pt.ready;
    assign store    = r_cnt < CW'(MAX_CONTOUR_POINTS);
    assign out_free = !r_o_vld || o_seg.ready;
    assign can_emit = !r_pend_vld || out_free;
    assign ram_re   = (r_state == S_RD);
    assign idx_inc  = r_idx + 1'b1;

    assign i_pt.ready = (r_state == S_IDLE);

    qcs_ram #(
        .W (QCS_POINT_W),
        .D (MAX_CONTOUR_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (in_pt),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // shared midpoint unit: wrap pair in the wrap state, neighbor pair while stepping
    assign mid_a = (r_state == S_WRAP) ? r_last  : r_prev;
    assign mid_b = (r_state == S_WRAP) ? r_first : rd_pt;

    qcs_mid u_mid (
        .i_a (mid_a),
        .i_b (mid_b),
        .o_x (mid_x),
        .o_y (mid_y)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_num      = r_num;
        n_idx      = r_idx;
        n_ovf_b    = r_ovf_b;
        n_first    = r_first;
        n_last     = r_last;
        n_prev     = r_prev;
        n_tx       = r_tx;
        n_ty       = r_ty;
        emit_req   = 1'b0;
        e_sx       = r_tx;
        e_sy       = r_ty;
        e_cx       = r_tx;
        e_cy       = r_ty;
        flush_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (store) begin
                        n_cnt  = r_cnt + 1'b1;
                        n_last = in_pt;
                        if (r_cnt == '0) begin
                            n_first = in_pt;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_pt.closes_contour) begin
                        n_num   = store ? CW'(r_cnt + 1'b1) : r_cnt;
                        n_ovf_b = r_ovf || !store;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_idx   = CW'(1);
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                emit_req = !r_first.on && !r_last.on;
                e_sx     = mid_x;
                e_sy     = mid_y;
                e_cx     = r_first.x;
                e_cy     = r_first.y;
                if (!emit_req || can_emit) begin
                    n_tx    = r_first.x;
                    n_ty    = r_first.y;
                    n_prev  = r_first;
                    if (r_num == '0) begin
                        n_state = S_FLUSH;
                    end else if (r_num == CW'(1)) begin
                        n_state = S_LAST;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (rd_pt.on) begin
                    emit_req = r_prev.on;
                end else begin
                    emit_req = 1'b1;
                    if (!r_prev.on) begin
                        e_sx = mid_x;
                        e_sy = mid_y;
                    end
                    e_cx = rd_pt.x;
                    e_cy = rd_pt.y;
                end
                if (!emit_req || can_emit) begin
                    n_tx    = rd_pt.on ? rd_pt.x : e_sx;
                    n_ty    = rd_pt.on ? rd_pt.y : e_sy;
                    n_prev  = rd_pt;
                    n_idx   = idx_inc;
                    n_state = (idx_inc == r_num) ? S_LAST : S_RD;
                end
            end
            S_LAST: begin
                emit_req = r_last.on;
                if (!r_first.on) begin
                    e_cx = r_first.x;
                    e_cy = r_first.y;
                end
                if (!emit_req || can_emit) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    flush_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign do_emit  = emit_req && can_emit;
    assign out_load = (do_emit && r_pend_vld) || flush_load;

    always_comb begin
        n_pend_vld = r_pend_vld;
        n_seg_cnt  = r_seg_cnt;
        if (accept && i_pt.closes_contour) begin
            n_seg_cnt = '0;
        end
        if (do_emit) begin
            n_pend_vld = 1'b1;
            n_seg_cnt  = r_seg_cnt + 1'b1;
        end else if (flush_load) begin
            n_pend_vld = 1'b0;
        end
        n_o_vld = r_o_vld;
        if (out_load) begin
            n_o_vld = 1'b1;
        end else if (o_seg.ready) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
            r_pend_vld <= n_pend_vld;
            r_o_vld    <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_idx     <= n_idx;
        r_ovf_b   <= n_ovf_b;
        r_first   <= n_first;
        r_last    <= n_last;
        r_prev    <= n_prev;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_seg_cnt <= n_seg_cnt;
        if (do_emit) begin
            r_pend_sx <= e_sx;
            r_pend_sy <= e_sy;
            r_pend_cx <= e_cx;
            r_pend_cy <= e_cy;
        end
        if (out_load) begin
            r_o_sx    <= r_pend_sx;
            r_o_sy    <= r_pend_sy;
            r_o_cx    <= r_pend_cx;
            r_o_cy    <= r_pend_cy;
            r_o_final <= flush_load;
            r_o_total <= flush_load ? r_seg_cnt : '0;
            r_o_drop  <= r_ovf_b;
        end
    end

    assign o_seg.valid          = r_o_vld;
    assign o_seg.start_x        = r_o_sx;
    assign o_seg.start_y        = r_o_sy;
    assign o_seg.ctrl_x         = r_o_cx;
    assign o_seg.ctrl_y         = r_o_cy;
    assign o_seg.final_segment  = r_o_final;
    assign o_seg.segment_total  = r_o_total;
    assign o_seg.points_dropped = r_o_drop;

    `QCS_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= CW'(MAX_CONTOUR_POINTS))
    `QCS_ASSERT_IMP(a_idx_range, r_state == S_STEP, r_idx < r_num)
    `QCS_ASSERT_IMP(a_final_total, r_o_vld && r_o_final, r_o_total != '0)
    `QCS_ASSERT_IMP(a_idle_clean, r_state == S_IDLE, !r_pend_vld)
    `QCS_ASSERT_NXT(a_close_clears, accept && i_pt.closes_contour, r_cnt == '0 && !r_ovf)

endmodule
